@@ src/rtc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtc_pkg
// Types, register codes and reset values shared by the row and column
// transposition cipher unit.
// ---------------------------------------------------------------------------
package rtc_pkg;

	localparam int BYTE_W     = 8;
	localparam int KEY_W      = 3;
	localparam int KEY_REG_W  = 24;
	localparam int ROWCNT_W   = 4;
	localparam int LEN_W      = 7;
	// byte counts never exceed 64 cells for any allowed block shape
	localparam int COUNT_W    = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE        = 3'd0,
		REG_ROW_COUNT   = 3'd1,
		REG_COLUMN_KEY  = 3'd2,
		REG_ROW_KEY     = 3'd3,
		REG_ORIG_LENGTH = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		MODE_ENCRYPT = 1'b0,
		MODE_DECRYPT = 1'b1
	} mode_t;

	localparam logic [ROWCNT_W-1:0]  ROW_COUNT_RST  = 4'd8;
	localparam logic [KEY_REG_W-1:0] COLUMN_KEY_RST = 24'd16434824;
	localparam logic [KEY_REG_W-1:0] ROW_KEY_RST    = 24'd16434824;
	localparam logic [LEN_W-1:0]     ORIG_LEN_RST   = 7'd64;

	typedef struct packed {
		mode_t                mode;
		logic [ROWCNT_W-1:0]  row_count;
		logic [KEY_REG_W-1:0] column_key;
		logic [KEY_REG_W-1:0] row_key;
		logic [LEN_W-1:0]     original_length;
	} cfg_t;

	typedef struct packed {
		logic               bank;
		logic [COUNT_W-1:0] count;
		logic               overflow;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              last;
		logic              err;
	} res_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	function automatic logic [KEY_W-1:0] key_entry(input logic [KEY_REG_W-1:0] key,
			input logic [KEY_W-1:0] idx);
		key_entry = key[KEY_W*idx +: KEY_W];
	endfunction

endpackage

@@ src/rtc_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtc interfaces
// Message byte, result and configuration write channels, valid/ready.
// ---------------------------------------------------------------------------
interface rtc_msg_if;
	import rtc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface rtc_res_if;
	import rtc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;
	logic              error_code;
	modport source (output valid, out_byte, out_last, error_code, input ready);
	modport sink (input valid, out_byte, out_last, error_code, output ready);
endinterface

interface rtc_cfg_if;
	import rtc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/row_column_transposition_cipher_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// row_column_transposition_cipher_unit
// Row and column transposition of a MAX_ROWS by COLS byte block.
// ---------------------------------------------------------------------------
// Message bytes are taken at one per cycle and stored row by row in one of
// two banks of a single store RAM; the byte marked last closes the message.
// Once the message is closed, the output sequencer checks its length and
// then emits one result byte per cycle while result is ready, limited by
// the single read port of the store: clamped row_count * COLS bytes when
// encrypting, the kept original length when decrypting, or a single error
// result. Loading of the next message runs alongside the output burst; input
// stalls only while both banks hold messages still waiting to be emitted.
// Cells past the fill count of a message read as zero, so the store needs no
// clearing pass after reset or between messages. Configuration is written
// through cfg, always ready, and must only change while the unit is idle.
module row_column_transposition_cipher_unit #(
	parameter int COLS     = 8,
	parameter int MAX_ROWS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	rtc_msg_if.sink   message,
	rtc_res_if.source result,
	rtc_cfg_if.sink   cfg
);
	import rtc_pkg::*;

	localparam int CELLS  = MAX_ROWS * COLS;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int ADDR_W = CELL_W + 1;
	localparam int DEPTH  = 2 ** ADDR_W;

	cfg_t              cfg_q;
	job_t              push_job, head;
	q_stat_t           q_stat;
	logic              push, pop, we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [BYTE_W-1:0] wdata, rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= MODE_ENCRYPT;
			cfg_q.row_count       <= ROW_COUNT_RST;
			cfg_q.column_key      <= COLUMN_KEY_RST;
			cfg_q.row_key         <= ROW_KEY_RST;
			cfg_q.original_length <= ORIG_LEN_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MODE:        cfg_q.mode <= mode_t'(cfg.data[0]);
				REG_ROW_COUNT:   cfg_q.row_count <= cfg.data[ROWCNT_W-1:0];
				REG_COLUMN_KEY:  cfg_q.column_key <= cfg.data[KEY_REG_W-1:0];
				REG_ROW_KEY:     cfg_q.row_key <= cfg.data[KEY_REG_W-1:0];
				REG_ORIG_LENGTH: cfg_q.original_length <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	rtc_front #(
		.CELLS  (CELLS),
		.ADDR_W (ADDR_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.message (message),
		.q_stat  (q_stat),
		.push    (push),
		.job     (push_job),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata)
	);

	rtc_job_fifo u_job_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	rtc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	rtc_back #(
		.COLS     (COLS),
		.MAX_ROWS (MAX_ROWS),
		.ADDR_W   (ADDR_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.raddr  (raddr),
		.rdata  (rdata),
		.result (result)
	);

	// an error result is a lone zero byte closing its message
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.error_code |-> result.out_last && result.out_byte == '0)
		else $error("error result not a closing zero byte");

	// a closed message is queued for the output side
	assert property (@(posedge clk) disable iff (!arst_n)
		message.valid && message.ready && message.last_byte |=> !q_stat.empty)
		else $error("closed message missing from job queue");

	// the sequencer only retires a job that exists
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("job retired from empty queue");

endmodule

@@ src/rtc_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtc_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module rtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/rtc_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtc_front
// Loads message bytes into the current store bank and hands a finished
// message to the job queue as bank, byte count and overflow.
// ---------------------------------------------------------------------------
module rtc_front #(
	parameter int CELLS  = 64,
	parameter int ADDR_W = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	rtc_msg_if.sink         message,
	input  rtc_pkg::q_stat_t q_stat,
	output logic            push,
	output rtc_pkg::job_t   job,
	output logic            we,
	output logic [ADDR_W-1:0] waddr,
	output logic [rtc_pkg::BYTE_W-1:0] wdata
);
	import rtc_pkg::*;

	logic               bank_q;
	logic [COUNT_W-1:0] count_q;
	logic               ovf_q;
	logic               accept;
	logic               room;
	logic [COUNT_W-1:0] count_next;
	logic               ovf_next;

	// a free bank exists whenever the queue has a free slot
	assign message.ready = !q_stat.full;
	assign accept        = message.valid && message.ready;
	assign room          = count_q < COUNT_W'(CELLS);
	assign count_next    = room ? count_q + COUNT_W'(1) : count_q;
	assign ovf_next      = ovf_q || !room;

	assign we    = accept && room;
	assign waddr = {bank_q, count_q[ADDR_W-2:0]};
	assign wdata = message.data_byte;

	assign push         = accept && message.last_byte;
	assign job.bank     = bank_q;
	assign job.count    = count_next;
	assign job.overflow = ovf_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 1'b0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (message.last_byte) begin
				bank_q  <= !bank_q;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_next;
				ovf_q   <= ovf_next;
			end
		end
	end

endmodule

@@ src/rtc_job_fifo.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtc_job_fifo
// Two entry queue of finished messages between loader and output sequencer.
// ---------------------------------------------------------------------------
module rtc_job_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rtc_pkg::job_t    push_job,
	input  logic             pop,
	output rtc_pkg::job_t    head,
	output rtc_pkg::q_stat_t q_stat
);
	import rtc_pkg::*;

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head         = mem_q[rd_q];
	assign q_stat.full  = cnt_q == 2'd2;
	assign q_stat.empty = cnt_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ src/rtc_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtc_back
// Checks the length of the queued message and walks the output block,
// reading one permuted cell per cycle, when credit allows, into a two entry result buffer.
// ---------------------------------------------------------------------------
module rtc_back #(
	parameter int COLS     = 8,
	parameter int MAX_ROWS = 8,
	parameter int ADDR_W   = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rtc_pkg::cfg_t    cfg,
	input  rtc_pkg::job_t    head,
	input  rtc_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic [ADDR_W-1:0] raddr,
	input  logic [rtc_pkg::BYTE_W-1:0] rdata,
	rtc_res_if.source        result
);
	import rtc_pkg::*;

	back_state_t st_q, st_d;

	logic [KEY_W-1:0]    i_q, j_q;
	logic [COUNT_W-1:0]  k_q;
	logic [ROWCNT_W-1:0] rows;
	logic [COUNT_W-1:0]  cells, lo, keep, total, idx;
	logic                len_bad, job_err, is_last;
	logic [KEY_W-1:0]    src_r, src_c, enc_r, enc_c, dec_r, dec_c;
	logic                src_ok, dec_rf, dec_cf, zero;
	logic                issue, issue_ok, issue_err;

	logic                infl_s1, zero_s1, last_s1, err_s1;

	res_t       oq_q [2];
	logic       oq_wr_q, oq_rd_q;
	logic [1:0] oq_cnt_q, occ;
	logic       out_pop;

	// block shape and length check
	always_comb begin
		if (cfg.row_count == '0) begin
			rows = ROWCNT_W'(1);
		end else if (cfg.row_count > ROWCNT_W'(MAX_ROWS)) begin
			rows = ROWCNT_W'(MAX_ROWS);
		end else begin
			rows = cfg.row_count;
		end
		cells = COUNT_W'(rows) * COUNT_W'(COLS);
		lo    = cells - COUNT_W'(COLS);
		if (cfg.original_length == '0) begin
			keep = COUNT_W'(1);
		end else if (cfg.original_length > cells) begin
			keep = cells;
		end else begin
			keep = cfg.original_length;
		end
		if (cfg.mode == MODE_ENCRYPT) begin
			len_bad = !(head.count > lo && head.count <= cells);
			total   = cells;
		end else begin
			len_bad = head.count != cells;
			total   = keep;
		end
		job_err = head.overflow || len_bad;
		is_last = (k_q + COUNT_W'(1)) == total;
	end

	// source cell of the current output position
	always_comb begin
		enc_r  = key_entry(cfg.row_key, i_q);
		enc_c  = key_entry(cfg.column_key, j_q);
		dec_rf = 1'b0;
		dec_cf = 1'b0;
		dec_r  = '0;
		dec_c  = '0;
		// decrypt inverts the mapping: the last matching key entry wins
		for (int s = 0; s < MAX_ROWS; s++) begin
			if (ROWCNT_W'(s) < rows && key_entry(cfg.row_key, KEY_W'(s)) == i_q) begin
				dec_rf = 1'b1;
				dec_r  = KEY_W'(s);
			end
		end
		for (int s = 0; s < COLS; s++) begin
			if (key_entry(cfg.column_key, KEY_W'(s)) == j_q) begin
				dec_cf = 1'b1;
				dec_c  = KEY_W'(s);
			end
		end
		if (cfg.mode == MODE_ENCRYPT) begin
			src_r  = enc_r;
			src_c  = enc_c;
			src_ok = ROWCNT_W'(enc_r) < rows && ROWCNT_W'(enc_c) < ROWCNT_W'(COLS);
		end else begin
			src_r  = dec_r;
			src_c  = dec_c;
			src_ok = dec_rf && dec_cf;
		end
		idx   = COUNT_W'(src_r) * COUNT_W'(COLS) + COUNT_W'(src_c);
		// cells beyond the fill count were never written this message
		zero  = !src_ok || idx >= head.count;
		raddr = {head.bank, idx[ADDR_W-2:0]};
	end

	// result buffer credit: buffered plus in flight never exceeds two
	assign out_pop  = result.valid && result.ready;
	assign occ      = oq_cnt_q + {1'b0, infl_s1};
	assign issue_ok = occ < 2'd2 || out_pop;

	always_comb begin
		st_d      = st_q;
		issue     = 1'b0;
		issue_err = 1'b0;
		pop       = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					if (job_err) begin
						if (issue_ok) begin
							issue     = 1'b1;
							issue_err = 1'b1;
							pop       = 1'b1;
						end
					end else begin
						st_d = BK_RUN;
					end
				end
			end
			BK_RUN: begin
				if (issue_ok) begin
					issue = 1'b1;
					if (is_last) begin
						pop  = 1'b1;
						st_d = BK_IDLE;
					end
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (st_q == BK_IDLE) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (issue) begin
			k_q <= k_q + COUNT_W'(1);
			if (j_q == KEY_W'(COLS - 1)) begin
				j_q <= '0;
				i_q <= i_q + KEY_W'(1);
			end else begin
				j_q <= j_q + KEY_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_s1 <= 1'b0;
		end else begin
			infl_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			zero_s1 <= issue_err || zero;
			last_s1 <= issue_err || is_last;
			err_s1  <= issue_err;
		end
	end

	always_ff @(posedge clk) begin
		if (infl_s1) begin
			oq_q[oq_wr_q].value <= zero_s1 ? '0 : rdata;
			oq_q[oq_wr_q].last  <= last_s1;
			oq_q[oq_wr_q].err   <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (infl_s1) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (out_pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			oq_cnt_q <= oq_cnt_q + {1'b0, infl_s1} - {1'b0, out_pop};
		end
	end

	assign result.valid      = oq_cnt_q != 2'd0;
	assign result.out_byte   = oq_q[oq_rd_q].value;
	assign result.out_last   = oq_q[oq_rd_q].last;
	assign result.error_code = oq_q[oq_rd_q].err;

endmodule
